>>> sv/weighted_audio_mixer_saturating_top_defines.svh
// ----------------------------------------------------------------------------
// Weighted audio mixer assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_AUDIO_MIXER_SATURATING_TOP_DEFINES_SVH
`define WEIGHTED_AUDIO_MIXER_SATURATING_TOP_DEFINES_SVH

// Same-cycle implication.
`define WAMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WAMS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/wams_pkg.sv
// ----------------------------------------------------------------------------
// Weighted audio mixer package
// Item and configuration types, widths, codes and divider constants.
// ----------------------------------------------------------------------------
package wams_pkg;

  localparam int SMP_W  = 32;   // sample width
  localparam int GAIN_W = 15;   // gain register width
  localparam int CFG_W  = 15;   // widest configuration register
  localparam int NSRC   = 3;    // number of sources
  localparam int P_W    = 47;   // signed product of a sample and a gain
  localparam int S_W    = 49;   // signed sum of three products
  localparam int MAG_W  = 48;   // magnitude of the sum
  localparam int X_W    = 38;   // clamped dividend
  localparam int M_W    = 39;   // reciprocal width
  localparam int D_W    = 7;    // residual divisor width
  localparam int PIPE_DEPTH = 7;

  // Weighted sums of n sources divide by 100n: shift by two, then 25n.
  localparam int PRE_SHIFT = 2;

  // Clamping the dividend here never changes a saturated result.
  localparam logic [X_W-1:0] X_MAX = X_W'(64'd75 << 31);

  localparam logic signed [SMP_W-1:0] U8_OFFSET = 32'sd128;

  // Sample format codes.
  localparam logic [1:0] FMT_U8  = 2'd0;
  localparam logic [1:0] FMT_S16 = 2'd1;
  localparam logic [1:0] FMT_S32 = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FORMAT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAIN_A = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAIN_B = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAIN_C = 3'd5;

  // Residual divisors and their truncated reciprocals scaled by 2^X_W.
  localparam logic [D_W-1:0] DIV_1  = D_W'(1);
  localparam logic [D_W-1:0] DIV_2  = D_W'(2);
  localparam logic [D_W-1:0] DIV_3  = D_W'(3);
  localparam logic [D_W-1:0] DIV_25 = D_W'(25);
  localparam logic [D_W-1:0] DIV_50 = D_W'(50);
  localparam logic [D_W-1:0] DIV_75 = D_W'(75);
  localparam logic [M_W-1:0] RECIP_1  = M_W'(64'd1 << X_W);
  localparam logic [M_W-1:0] RECIP_2  = M_W'((64'd1 << X_W) / 2);
  localparam logic [M_W-1:0] RECIP_3  = M_W'((64'd1 << X_W) / 3);
  localparam logic [M_W-1:0] RECIP_25 = M_W'((64'd1 << X_W) / 25);
  localparam logic [M_W-1:0] RECIP_50 = M_W'((64'd1 << X_W) / 50);
  localparam logic [M_W-1:0] RECIP_75 = M_W'((64'd1 << X_W) / 75);

  typedef struct packed {
    logic signed [SMP_W-1:0] sample_a;
    logic signed [SMP_W-1:0] sample_b;
    logic signed [SMP_W-1:0] sample_c;
    logic                    end_of_block;
  } in_item_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] mixed_sample;
    logic                    end_of_block_out;
  } out_item_t;

  typedef struct packed {
    logic [1:0]        sample_format;
    logic [1:0]        source_count;
    logic              weighted_mode;
    logic [GAIN_W-1:0] gain_a;
    logic [GAIN_W-1:0] gain_b;
    logic [GAIN_W-1:0] gain_c;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    sample_format: FMT_S16,
    source_count:  2'd2,
    weighted_mode: 1'b1,
    gain_a:        GAIN_W'(100),
    gain_b:        GAIN_W'(100),
    gain_c:        GAIN_W'(100)
  };

  // Control that travels with each item between pipeline stages.
  typedef struct packed {
    logic valid;
    logic eob;
  } stg_ctl_t;

  typedef logic signed [P_W-1:0] prod_t;

  typedef struct packed {
    logic [D_W-1:0] d;
    logic [M_W-1:0] m;
  } div_t;

  function automatic logic [1:0] eff_count(logic [1:0] cnt);
    return (cnt == 2'd0) ? 2'd1 : cnt;
  endfunction

  // A single source always takes the weighted path.
  function automatic logic eff_weighted(cfg_t c);
    return c.weighted_mode || (eff_count(c.source_count) == 2'd1);
  endfunction

  function automatic div_t div_const(cfg_t c);
    div_t dv;
    logic w;
    w = eff_weighted(c);
    case (eff_count(c.source_count))
      2'd2: begin
        dv.d = w ? DIV_50 : DIV_2;
        dv.m = w ? RECIP_50 : RECIP_2;
      end
      2'd3: begin
        dv.d = w ? DIV_75 : DIV_3;
        dv.m = w ? RECIP_75 : RECIP_3;
      end
      default: begin
        dv.d = w ? DIV_25 : DIV_1;
        dv.m = w ? RECIP_25 : RECIP_1;
      end
    endcase
    return dv;
  endfunction

endpackage

>>> sv/weighted_audio_mixer_saturating_top.sv
// ----------------------------------------------------------------------------
// Weighted audio mixer, saturating
// Mixes up to three sample streams with percentage gains or a plain average,
// then saturates to the configured sample format.
// ----------------------------------------------------------------------------
// Usage:
// Each input item carries one sample of each of three sources plus an
// end-of-block flag, and is taken on in_valid_i and in_ready_o both high.
// Each item yields exactly one output item (mixed sample and copied flag),
// taken on out_valid_o and out_ready_i both high.
// The configuration port writes one register per cycle with cfg_we_i high;
// the user must change registers only while the mixer holds no items, which
// the block itself does not enforce. The accepting edge loads the product
// stage and the item passes stage by stage to the output register. Unless the
// receiver stalls, throughput is one item per cycle, set by the seven register
// stages (product, sum, magnitude, partial products, estimate, correction,
// saturation), each of which takes a new item every cycle.
// Reset returns every register to its default (16-bit format, two sources,
// weighted, gains of 100) and empties the pipeline.
// When the receiver stalls, a finished item waits in the output register and
// the stages behind it keep filling; a stage holds only once the one ahead is
// full, so in_ready_o falls only with a full pipeline.
// ----------------------------------------------------------------------------
module weighted_audio_mixer_saturating_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [wams_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [wams_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  wams_pkg::in_item_t               in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output wams_pkg::out_item_t              out_item_o
);
  import wams_pkg::*;

  // The signed quotient needs one bit more than the divider's magnitude.
  localparam int V_W = X_W + 1;
  localparam logic signed [V_W-1:0] U8_HI  = V_W'(127);
  localparam logic signed [V_W-1:0] U8_LO  = V_W'(-128);
  localparam logic signed [V_W-1:0] S16_HI = V_W'(32767);
  localparam logic signed [V_W-1:0] S16_LO = V_W'(-32768);
  localparam logic signed [V_W-1:0] S32_HI = V_W'(64'sh7fffffff);
  localparam logic signed [V_W-1:0] S32_LO = V_W'(-64'sh80000000);

  cfg_t              cfg_q;

  stg_ctl_t          mul_ctl;
  logic              mul_rdy;
  prod_t             mul_prod [NSRC];

  stg_ctl_t          acc_ctl;
  logic              acc_rdy;
  logic [X_W-1:0]    acc_x;
  logic              acc_neg;

  stg_ctl_t          div_ctl;
  logic              div_rdy;
  logic [X_W-1:0]    div_q;
  logic              div_neg;

  logic signed [V_W-1:0] val;
  logic signed [V_W-1:0] sat;
  logic signed [V_W-1:0] hi;
  logic signed [V_W-1:0] lo;
  logic [SMP_W-1:0]      res;
  out_item_t             out_d;
  out_item_t             out_q;
  logic                  out_vld_q;
  logic                  out_adv;

  // Configuration registers. Writes to unused indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_FORMAT: cfg_q.sample_format <= cfg_data_i[1:0];
        CFG_IDX_COUNT:  cfg_q.source_count  <= cfg_data_i[1:0];
        CFG_IDX_MODE:   cfg_q.weighted_mode <= cfg_data_i[0];
        CFG_IDX_GAIN_A: cfg_q.gain_a        <= cfg_data_i[GAIN_W-1:0];
        CFG_IDX_GAIN_B: cfg_q.gain_b        <= cfg_data_i[GAIN_W-1:0];
        CFG_IDX_GAIN_C: cfg_q.gain_c        <= cfg_data_i[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Stage one: decode and per-source multiply.
  wams_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (in_valid_i),
    .ready_o (mul_rdy),
    .item_i  (in_item_i),
    .ctl_o   (mul_ctl),
    .ready_i (acc_rdy),
    .prod_o  (mul_prod)
  );

  // Stages two and three: sum, then sign, magnitude and clamp.
  wams_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .ctl_i   (mul_ctl),
    .ready_o (acc_rdy),
    .prod_i  (mul_prod),
    .ctl_o   (acc_ctl),
    .ready_i (div_rdy),
    .x_o     (acc_x),
    .neg_o   (acc_neg)
  );

  // Stages four to six: division by n, or by 25n if weighted (n sources).
  wams_cdiv u_cdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .ctl_i   (acc_ctl),
    .ready_o (div_rdy),
    .x_i     (acc_x),
    .neg_i   (acc_neg),
    .ctl_o   (div_ctl),
    .ready_i (out_adv),
    .q_o     (div_q),
    .neg_o   (div_neg)
  );

  assign in_ready_o = mul_rdy;

  // Stage seven: restore the sign, saturate to the format, re-offset 8-bit.
  // An 8-bit mix of +128 or more clips to 255.
  always_comb begin
    val = $signed({1'b0, div_q});
    if (div_neg) begin
      val = -val;
    end
    case (cfg_q.sample_format)
      FMT_U8: begin
        hi = U8_HI;
        lo = U8_LO;
      end
      FMT_S16: begin
        hi = S16_HI;
        lo = S16_LO;
      end
      default: begin
        hi = S32_HI;
        lo = S32_LO;
      end
    endcase
    if (val > hi) begin
      sat = hi;
    end else if (val < lo) begin
      sat = lo;
    end else begin
      sat = val;
    end
    res = sat[SMP_W-1:0];
    if (cfg_q.sample_format == FMT_U8) begin
      res = res + U8_OFFSET;
    end
    out_d.mixed_sample     = $signed(res);
    out_d.end_of_block_out = div_ctl.eob;
  end

  // The output register holds a result for as long as the receiver stalls.
  assign out_adv = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_adv) begin
      out_vld_q <= div_ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && div_ctl.valid) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

>>> sv/wams_mult.sv
// ----------------------------------------------------------------------------
// Weighted audio mixer product stage
// Decodes the three samples and multiplies each by its effective gain.
// ----------------------------------------------------------------------------
module wams_mult (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wams_pkg::cfg_t      cfg_i,
  input  logic                valid_i,
  output logic                ready_o,
  input  wams_pkg::in_item_t  item_i,
  output wams_pkg::stg_ctl_t  ctl_o,
  input  logic                ready_i,
  output wams_pkg::prod_t     prod_o [wams_pkg::NSRC]
);
  import wams_pkg::*;

  function automatic logic signed [SMP_W-1:0] decode(logic [SMP_W-1:0] raw,
                                                     logic [1:0] fmt);
    logic signed [SMP_W-1:0] v;
    case (fmt)
      FMT_U8:  v = $signed({24'd0, raw[7:0]}) - U8_OFFSET;
      FMT_S16: v = $signed({{16{raw[15]}}, raw[15:0]});
      default: v = $signed(raw);
    endcase
    return v;
  endfunction

  logic [1:0]                n_eff;
  logic                      wgt;
  logic signed [SMP_W-1:0]   smp   [NSRC];
  logic [GAIN_W-1:0]         gain  [NSRC];
  logic signed [GAIN_W:0]    mul_g [NSRC];
  prod_t                     prod_d [NSRC];
  prod_t                     prod_q [NSRC];
  stg_ctl_t                  ctl_q;
  logic                      adv;

  assign n_eff = eff_count(cfg_i.source_count);
  assign wgt   = eff_weighted(cfg_i);

  assign smp[0] = decode(item_i.sample_a, cfg_i.sample_format);
  assign smp[1] = decode(item_i.sample_b, cfg_i.sample_format);
  assign smp[2] = decode(item_i.sample_c, cfg_i.sample_format);

  assign gain[0] = cfg_i.gain_a;
  assign gain[1] = cfg_i.gain_b;
  assign gain[2] = cfg_i.gain_c;

  // Unused sources get a zero factor; the plain average uses a factor of one.
  always_comb begin
    for (int i = 0; i < NSRC; i++) begin
      if (2'(i) >= n_eff) begin
        mul_g[i] = '0;
      end else if (wgt) begin
        mul_g[i] = $signed({1'b0, gain[i]});
      end else begin
        mul_g[i] = (GAIN_W+1)'(1);
      end
      prod_d[i] = P_W'(smp[i]) * P_W'(mul_g[i]);
    end
  end

  assign adv     = !ctl_q.valid || ready_i;
  assign ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv) begin
      ctl_q <= '{valid: valid_i, eob: item_i.end_of_block};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;
  assign ctl_o  = ctl_q;

endmodule

>>> sv/wams_accum.sv
// ----------------------------------------------------------------------------
// Weighted audio mixer accumulate stages
// Sums the products, then forms the clamped magnitude for the divider.
// ----------------------------------------------------------------------------
module wams_accum (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  wams_pkg::cfg_t            cfg_i,
  input  wams_pkg::stg_ctl_t        ctl_i,
  output logic                      ready_o,
  input  wams_pkg::prod_t           prod_i [wams_pkg::NSRC],
  output wams_pkg::stg_ctl_t        ctl_o,
  input  logic                      ready_i,
  output logic [wams_pkg::X_W-1:0]  x_o,
  output logic                      neg_o
);
  import wams_pkg::*;

  logic signed [S_W-1:0] sum_d;
  logic signed [S_W-1:0] sum_q;
  logic [MAG_W-1:0]      mag;
  logic [MAG_W-1:0]      mag_sh;
  logic [X_W-1:0]        x_d;
  logic [X_W-1:0]        x_q;
  logic                  neg_q;
  stg_ctl_t              ctl_a_q;
  stg_ctl_t              ctl_b_q;
  logic                  adv_a;
  logic                  adv_b;

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NSRC; i++) begin
      sum_d = sum_d + S_W'(prod_i[i]);
    end
  end

  // The quotient truncates toward zero, so the divider works on the magnitude.
  always_comb begin
    mag    = MAG_W'(sum_q[S_W-1] ? -sum_q : sum_q);
    mag_sh = eff_weighted(cfg_i) ? (mag >> PRE_SHIFT) : mag;
    x_d    = (mag_sh > MAG_W'(X_MAX)) ? X_MAX : X_W'(mag_sh);
  end

  assign adv_b   = !ctl_b_q.valid || ready_i;
  assign adv_a   = !ctl_a_q.valid || adv_b;
  assign ready_o = adv_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
    end else begin
      if (adv_a) begin
        ctl_a_q <= ctl_i;
      end
      if (adv_b) begin
        ctl_b_q <= ctl_a_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_a && ctl_i.valid) begin
      sum_q <= sum_d;
    end
    if (adv_b && ctl_a_q.valid) begin
      x_q   <= x_d;
      neg_q <= sum_q[S_W-1];
    end
  end

  assign ctl_o = ctl_b_q;
  assign x_o   = x_q;
  assign neg_o = neg_q;

endmodule

>>> sv/wams_cdiv.sv
// ----------------------------------------------------------------------------
// Weighted audio mixer constant divider
// Divides by a small configured constant through a split reciprocal product
// and a single remainder correction.
// ----------------------------------------------------------------------------
module wams_cdiv (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  wams_pkg::cfg_t            cfg_i,
  input  wams_pkg::stg_ctl_t        ctl_i,
  output logic                      ready_o,
  input  logic [wams_pkg::X_W-1:0]  x_i,
  input  logic                      neg_i,
  output wams_pkg::stg_ctl_t        ctl_o,
  input  logic                      ready_i,
  output logic [wams_pkg::X_W-1:0]  q_o,
  output logic                      neg_o
);
  import wams_pkg::*;

  localparam int XL_W = X_W / 2;
  localparam int XH_W = X_W - XL_W;
  localparam int ML_W = XL_W;
  localparam int MH_W = M_W - ML_W;
  localparam int HH_W = XH_W + MH_W;
  localparam int HL_W = XH_W + ML_W;
  localparam int LH_W = XL_W + MH_W;
  localparam int LL_W = XL_W + ML_W;
  localparam int T_W  = X_W + M_W;

  div_t              dv;
  logic [XH_W-1:0]   xh;
  logic [XL_W-1:0]   xl;
  logic [MH_W-1:0]   mh;
  logic [ML_W-1:0]   ml;

  logic [HH_W-1:0]   pp_hh_q;
  logic [HL_W-1:0]   pp_hl_q;
  logic [LH_W-1:0]   pp_lh_q;
  logic [LL_W-1:0]   pp_ll_q;
  logic [X_W-1:0]    x_p_q;
  logic              neg_p_q;

  logic [T_W-1:0]    tot;
  logic [X_W-1:0]    q0_q;
  logic [X_W-1:0]    x_e_q;
  logic              neg_e_q;

  logic [X_W-1:0]    qd;
  logic [X_W-1:0]    rem;
  logic [X_W-1:0]    q_d;
  logic [X_W-1:0]    q_q;
  logic              neg_q;

  stg_ctl_t          ctl_p_q;
  stg_ctl_t          ctl_e_q;
  stg_ctl_t          ctl_r_q;
  logic              adv_p;
  logic              adv_e;
  logic              adv_r;

  assign dv = div_const(cfg_i);
  assign xh = x_i[X_W-1:XL_W];
  assign xl = x_i[XL_W-1:0];
  assign mh = dv.m[M_W-1:ML_W];
  assign ml = dv.m[ML_W-1:0];

  // Reassemble x * m and keep the bits above 2^X_W as the first estimate.
  assign tot = (T_W'(pp_hh_q) << (XL_W + ML_W))
             + (T_W'(pp_hl_q) << ML_W)
             + (T_W'(pp_lh_q) << XL_W)
             + T_W'(pp_ll_q);

  // The estimate is low by at most one, so the remainder stays below 2d.
  always_comb begin
    qd  = q0_q * X_W'(dv.d);
    rem = x_e_q - qd;
    q_d = q0_q + X_W'(rem >= X_W'(dv.d));
  end

  assign adv_r   = !ctl_r_q.valid || ready_i;
  assign adv_e   = !ctl_e_q.valid || adv_r;
  assign adv_p   = !ctl_p_q.valid || adv_e;
  assign ready_o = adv_p;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_p_q <= '0;
      ctl_e_q <= '0;
      ctl_r_q <= '0;
    end else begin
      if (adv_p) begin
        ctl_p_q <= ctl_i;
      end
      if (adv_e) begin
        ctl_e_q <= ctl_p_q;
      end
      if (adv_r) begin
        ctl_r_q <= ctl_e_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_p && ctl_i.valid) begin
      pp_hh_q <= HH_W'(xh) * HH_W'(mh);
      pp_hl_q <= HL_W'(xh) * HL_W'(ml);
      pp_lh_q <= LH_W'(xl) * LH_W'(mh);
      pp_ll_q <= LL_W'(xl) * LL_W'(ml);
      x_p_q   <= x_i;
      neg_p_q <= neg_i;
    end
    if (adv_e && ctl_p_q.valid) begin
      q0_q    <= tot[X_W +: X_W];
      x_e_q   <= x_p_q;
      neg_e_q <= neg_p_q;
    end
    if (adv_r && ctl_e_q.valid) begin
      q_q   <= q_d;
      neg_q <= neg_e_q;
    end
  end

  assign ctl_o = ctl_r_q;
  assign q_o   = q_q;
  assign neg_o = neg_q;

endmodule

>>> sv/wams_chk.sv
// ----------------------------------------------------------------------------
// Weighted audio mixer port checker
// Tracks items in flight at the ports and checks occupancy and flow control.
// ----------------------------------------------------------------------------
`include "weighted_audio_mixer_saturating_top_defines.svh"

module wams_chk (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_o,
  input  logic                             out_valid_o,
  input  logic                             out_ready_i,
  input  wams_pkg::out_item_t              out_item_o
);
  import wams_pkg::*;

  localparam int CNT_W = $clog2(PIPE_DEPTH + 2);

  logic [CNT_W-1:0] inflight_q;
  logic [CNT_W-1:0] inflight_d;
  logic             in_acc;
  logic             out_acc;

  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = out_valid_o && out_ready_i;
  assign inflight_d = inflight_q + CNT_W'(in_acc) - CNT_W'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // A result is shown only for an item that was taken in earlier.
  `WAMS_ASSERT_IMP(a_no_invented, out_valid_o, inflight_q != '0, "result without item")
  // The pipeline never holds more items than it has stages.
  `WAMS_ASSERT_IMP(a_depth, 1'b1, inflight_q <= CNT_W'(PIPE_DEPTH), "too many items")
  // Input back pressure only comes from a stalled output.
  `WAMS_ASSERT_IMP(a_ready, !in_ready_o, out_valid_o && !out_ready_i, "input stalled")
  // A stalled result stays put.
  `WAMS_ASSERT_NXT(a_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o), "result changed")

endmodule

bind weighted_audio_mixer_saturating_top wams_chk u_wams_chk (.*);

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Weighted audio mixer testbench
// Drives mixed sample items through the mixer under many register settings,
// predicts every mixed sample in 64-bit arithmetic and checks the results.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wams_pkg::*;

  // Run shape. The random part stops once about this many items are sent.
  localparam int unsigned RANDOM_ITEMS   = 1730;
  // The receiver's long hold-off, long enough to fill all seven stages.
  localparam int unsigned STALL_LONG     = 48;
  // Cycles with no item moved on either side before the run is abandoned.
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  // Extra settle time after the last result, a bit above the latency.
  localparam int unsigned DRAIN_CYCLES   = 12;

  // The format code that the package leaves unnamed; it mixes as 32-bit.
  localparam logic [1:0] FMT_UNDEF = 2'd3;
  // Register indexes that map to no register; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_B = 3'd7;
  localparam logic [GAIN_W-1:0] GAIN_MAX = 15'h7FFF;

  // The scoreboard keeps its own copy of the registers and predicts each
  // mixed sample when its item is accepted.
  class mix_scoreboard;
    cfg_t        cfg;
    out_item_t   pending_mix_q[$];
    int unsigned n_checked;
    int unsigned n_errors;
    int unsigned n_eob;
    int unsigned fmt_seen[4];

    function new();
      cfg = CFG_RESET;
    endfunction

    function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_IDX_FORMAT: cfg.sample_format = data[1:0];
        CFG_IDX_COUNT:  cfg.source_count  = data[1:0];
        CFG_IDX_MODE:   cfg.weighted_mode = data[0];
        CFG_IDX_GAIN_A: cfg.gain_a        = data[GAIN_W-1:0];
        CFG_IDX_GAIN_B: cfg.gain_b        = data[GAIN_W-1:0];
        CFG_IDX_GAIN_C: cfg.gain_c        = data[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function out_item_t mix_predict(in_item_t it);
      logic [SMP_W-1:0] raw [NSRC];
      longint smp [NSRC];
      longint gn [NSRC];
      longint acc;
      longint quo;
      longint lo;
      longint hi;
      int n;
      out_item_t r;
      raw[0] = it.sample_a;
      raw[1] = it.sample_b;
      raw[2] = it.sample_c;
      gn[0] = longint'(cfg.gain_a);
      gn[1] = longint'(cfg.gain_b);
      gn[2] = longint'(cfg.gain_c);
      for (int i = 0; i < NSRC; i++) begin
        case (cfg.sample_format)
          FMT_U8:  smp[i] = longint'(raw[i][7:0]) - 128;
          FMT_S16: smp[i] = longint'($signed(raw[i][15:0]));
          default: smp[i] = longint'($signed(raw[i]));
        endcase
      end
      n = (cfg.source_count == 2'd0) ? 1 : int'(cfg.source_count);
      acc = 0;
      if (cfg.weighted_mode || n == 1) begin
        for (int i = 0; i < n; i++) acc += smp[i] * gn[i];
        quo = acc / longint'(100 * n);
      end else begin
        for (int i = 0; i < n; i++) acc += smp[i];
        quo = acc / longint'(n);
      end
      case (cfg.sample_format)
        FMT_U8: begin
          lo = -128;
          hi = 127;
        end
        FMT_S16: begin
          lo = -32768;
          hi = 32767;
        end
        default: begin
          lo = -longint'(32'h7FFF_FFFF) - 1;
          hi = longint'(32'h7FFF_FFFF);
        end
      endcase
      if (quo > hi) quo = hi;
      if (quo < lo) quo = lo;
      if (cfg.sample_format == FMT_U8) quo += 128;
      r.mixed_sample     = quo[SMP_W-1:0];
      r.end_of_block_out = it.end_of_block;
      return r;
    endfunction

    function void note_input(in_item_t it);
      pending_mix_q.push_back(mix_predict(it));
      fmt_seen[cfg.sample_format]++;
      if (it.end_of_block) n_eob++;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_mix_q.size() == 0) begin
        $error("mixed output item with no input item pending: %0d", got.mixed_sample);
        n_errors++;
        return;
      end
      want = pending_mix_q.pop_front();
      n_checked++;
      if (got.mixed_sample !== want.mixed_sample) begin
        $error("mixed_sample: expected %0d, got %0d", want.mixed_sample, got.mixed_sample);
        n_errors++;
      end
      if (got.end_of_block_out !== want.end_of_block_out) begin
        $error("end_of_block_out: expected %0b, got %0b",
               want.end_of_block_out, got.end_of_block_out);
        n_errors++;
      end
    endfunction
  endclass

  // Every input of the mixer starts at a known value.
  logic                 clk      = 1'b0;
  logic                 rst_n    = 1'b0;
  logic                 cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx  = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  in_item_t             in_item  = '0;
  logic                 in_ready;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_item;

  // Knobs that the stimulus process sets for the receiver and for itself.
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit hold_req   = 1'b0;

  int unsigned   quiet_cycles = 0;
  int unsigned   n_settings   = 0;
  mix_scoreboard sb;

  weighted_audio_mixer_saturating_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Both handshakes are sampled here, right after the edge and before any
  // nonblocking update of that edge lands, so every value seen is the one the
  // mixer saw. Inputs are noted first; a result can never belong to an item
  // taken at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_item);
      if (out_valid && out_ready) sb.check_result(out_item);
    end
  end

  // The watchdog counts edges at which no item moves on either side. Every
  // legal pause in this run is far shorter than the limit.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // About one gap in ten is long.
  function automatic int unsigned gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
  endfunction

  // The receiver runs on its own. When asked for a hold-off it keeps ready
  // low for a fixed stretch that it counts itself, so the pipeline fills and
  // the mixer has to stall its input while the sender keeps offering.
  initial begin : receiver
    int unsigned g;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (STALL_LONG) @(posedge clk);
        out_ready <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        g = gap_len();
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic in_item_t mix_item(logic [SMP_W-1:0] a, logic [SMP_W-1:0] b,
                                        logic [SMP_W-1:0] c, logic eob);
    in_item_t it;
    it.sample_a     = a;
    it.sample_b     = b;
    it.sample_c     = c;
    it.end_of_block = eob;
    return it;
  endfunction

  function automatic cfg_t make_cfg(logic [1:0] fmt, logic [1:0] cnt, logic mode,
                                    logic [GAIN_W-1:0] ga, logic [GAIN_W-1:0] gb,
                                    logic [GAIN_W-1:0] gc);
    cfg_t c;
    c.sample_format = fmt;
    c.source_count  = cnt;
    c.weighted_mode = mode;
    c.gain_a        = ga;
    c.gain_b        = gb;
    c.gain_c        = gc;
    return c;
  endfunction

  // Gains lean toward the interesting ends: zero, full scale, unity, and
  // small values that keep sums away from the clip.
  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return GAIN_MAX;
      2:       return GAIN_W'(100);
      3:       return GAIN_W'($urandom_range(0, 32767));
      default: return GAIN_W'($urandom_range(0, 400));
    endcase
  endfunction

  // A sample in the given format: sometimes a full-scale or boundary value,
  // often with junk above the bits the format decodes, sometimes pure noise.
  function automatic logic [SMP_W-1:0] pick_sample(logic [1:0] fmt);
    logic [SMP_W-1:0] junk;
    logic [SMP_W-1:0] v;
    int unsigned      sel;
    int unsigned      k;
    junk = $urandom;
    sel  = $urandom_range(0, 7);
    k    = $urandom_range(0, 3);
    if (sel == 0) return $urandom;
    case (fmt)
      FMT_U8: begin
        v = $urandom_range(0, 255);
        if (sel <= 2) v = (k == 0) ? 32'h00 : (k == 1) ? 32'hFF : (k == 2) ? 32'h80 : 32'h7F;
        if ($urandom_range(0, 1)) v[31:8] = junk[31:8];
      end
      FMT_S16: begin
        v = $urandom_range(0, 16'hFFFF);
        if (sel <= 2) begin
          v = (k == 0) ? 32'h0000 : (k == 1) ? 32'h7FFF : (k == 2) ? 32'h8000 : 32'hFFFF;
        end
        if ($urandom_range(0, 1)) v[31:16] = junk[31:16];
      end
      default: begin
        v = junk;
        if (sel <= 2) begin
          v = (k == 0) ? 32'h0 : (k == 1) ? 32'h7FFF_FFFF :
              (k == 2) ? 32'h8000_0000 : 32'hFFFF_FFFF;
        end else if (sel == 3) begin
          v = SMP_W'($urandom_range(0, 2000)) - 32'd1000;
        end
      end
    endcase
    return v;
  endfunction

  // Sends one item: an optional gap with valid low, then valid held high with
  // a stable payload until the edge at which the mixer takes it.
  task automatic push_item(in_item_t it);
    int unsigned g;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      g = gap_len();
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stops sending and waits until every predicted mix has been checked.
  // The first edge lets the monitor note an item taken at this very edge.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_mix_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all six registers, one per edge, with noise in the bits above the
  // narrow fields. Optionally also writes the two unmapped indexes.
  task automatic load_settings(cfg_t c, bit with_unmapped);
    logic [CFG_IDX_W-1:0] idx_q[$];
    logic [CFG_W-1:0]     val_q[$];
    logic [CFG_W-1:0]     v;
    v = CFG_W'($urandom);
    v[1:0] = c.sample_format;
    idx_q.push_back(CFG_IDX_FORMAT);
    val_q.push_back(v);
    v = CFG_W'($urandom);
    v[1:0] = c.source_count;
    idx_q.push_back(CFG_IDX_COUNT);
    val_q.push_back(v);
    v = CFG_W'($urandom);
    v[0] = c.weighted_mode;
    idx_q.push_back(CFG_IDX_MODE);
    val_q.push_back(v);
    idx_q.push_back(CFG_IDX_GAIN_A);
    val_q.push_back(c.gain_a);
    idx_q.push_back(CFG_IDX_GAIN_B);
    val_q.push_back(c.gain_b);
    idx_q.push_back(CFG_IDX_GAIN_C);
    val_q.push_back(c.gain_c);
    if (with_unmapped) begin
      idx_q.push_back(IDX_UNMAPPED_A);
      val_q.push_back(CFG_W'($urandom));
      idx_q.push_back(IDX_UNMAPPED_B);
      val_q.push_back(CFG_W'($urandom));
    end
    foreach (idx_q[i]) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= idx_q[i];
      cfg_data <= val_q[i];
      sb.apply_write(idx_q[i], val_q[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // The stimulus process: reset, a directed part that walks the corners of
  // every format and mode, then random phases, each under its own settings.
  initial begin : stimulus
    cfg_t        c;
    int unsigned phase;
    int unsigned n_sent;
    int unsigned n_phase;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Settings after reset: 16-bit, two sources, weighted, unity gains.
    // Full-scale pairs give full scale, and junk above bit 15 must be dropped.
    push_item(mix_item(32'h0000_7FFF, 32'h0000_7FFF, 32'h1234_5678, 1'b1));
    push_item(mix_item(32'hFFFF_8000, 32'hABCD_8000, 32'h0, 1'b0));
    push_item(mix_item(32'h0001_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0));

    // One 8-bit source at 200 percent. A mix of exactly +128 must give 255,
    // one step below gives 254, and the bottom clips to 0. Plain mode is set,
    // but a single source is always weighted.
    wait_drained();
    load_settings(make_cfg(FMT_U8, 2'd1, 1'b0, GAIN_W'(200), '0, '0), 1'b1);
    push_item(mix_item(32'h0000_00C0, 32'h0, 32'h0, 1'b0));
    push_item(mix_item(32'hFFFF_FFBF, 32'h5555_5555, 32'h0, 1'b1));
    push_item(mix_item(32'h0000_0000, 32'hFFFF_FFFF, 32'h0, 1'b0));
    push_item(mix_item(32'hAAAA_AA80, 32'h0, 32'hFFFF_FFFF, 1'b0));

    // 32-bit, three sources at full-scale gain: both clips of the 32-bit range.
    wait_drained();
    load_settings(make_cfg(FMT_S32, 2'd3, 1'b1, GAIN_MAX, GAIN_MAX, GAIN_MAX), 1'b0);
    push_item(mix_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
    push_item(mix_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0));
    push_item(mix_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b0));

    // The undefined format mixes as 32-bit, and a source count of zero acts
    // as one source. Negative quotients truncate toward zero.
    wait_drained();
    load_settings(make_cfg(FMT_UNDEF, 2'd0, 1'b0, GAIN_W'(50), GAIN_MAX, GAIN_MAX), 1'b0);
    push_item(mix_item(32'hFFFF_FFFD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
    push_item(mix_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));

    // Plain average of three 16-bit sources: truncation and both range ends.
    wait_drained();
    load_settings(make_cfg(FMT_S16, 2'd3, 1'b0, '0, '0, '0), 1'b0);
    push_item(mix_item(32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0, 1'b0));
    push_item(mix_item(32'h0000_7FFF, 32'h0000_7FFF, 32'h0000_7FFF, 1'b0));
    push_item(mix_item(32'hFFFF_8000, 32'h1234_8000, 32'h0000_8000, 1'b1));

    // Plain average of two 32-bit sources.
    wait_drained();
    load_settings(make_cfg(FMT_S32, 2'd2, 1'b0, GAIN_MAX, '0, GAIN_MAX), 1'b0);
    push_item(mix_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
    push_item(mix_item(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
    push_item(mix_item(32'hFFFF_FFFD, 32'h0, 32'h0, 1'b1));

    // Three 8-bit sources at full-scale gain clip both ways.
    wait_drained();
    load_settings(make_cfg(FMT_U8, 2'd3, 1'b1, GAIN_MAX, GAIN_MAX, GAIN_MAX), 1'b0);
    push_item(mix_item(32'h0000_00FF, 32'hFFFF_FFFF, 32'h0000_00FF, 1'b0));
    push_item(mix_item(32'h0000_0000, 32'hFFFF_FF00, 32'h0000_0000, 1'b1));

    // Random phases. The first two use the largest and the smallest value of
    // every register; later ones draw their settings at random. Every fourth
    // phase asks the receiver for a long hold-off while the sender streams
    // without gaps, so the pipeline fills and the input stalls. Between
    // phases the sender waits until every result is back.
    phase  = 0;
    n_sent = 0;
    while (n_sent < RANDOM_ITEMS) begin
      case (phase)
        0: c = make_cfg(FMT_UNDEF, 2'd3, 1'b1, GAIN_MAX, GAIN_MAX, GAIN_MAX);
        1: c = make_cfg(FMT_U8, 2'd0, 1'b0, '0, '0, '0);
        default: begin
          c = make_cfg(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                       1'($urandom_range(0, 1)), pick_gain(), pick_gain(), pick_gain());
        end
      endcase
      wait_drained();
      load_settings(c, (phase % 5) == 3);
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      if ((phase % 4) == 2) begin
        hold_req   = 1'b1;
        tx_idle_en = 1'b0;
      end
      n_phase = $urandom_range(40, 120);
      repeat (n_phase) begin
        push_item(mix_item(pick_sample(c.sample_format), pick_sample(c.sample_format),
                           pick_sample(c.sample_format), $urandom_range(0, 7) == 0));
        n_sent++;
      end
      phase++;
    end

    // Let the last results out, then give any stray output time to show up.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d mixed samples checked under %0d register settings, %0d block ends",
             sb.n_checked, n_settings, sb.n_eob);
    $display("summary: items per format: u8 %0d, s16 %0d, s32 %0d, undefined code %0d",
             sb.fmt_seen[0], sb.fmt_seen[1], sb.fmt_seen[2], sb.fmt_seen[3]);
    if (sb.n_errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
